/* design/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the forest fire automaton step block.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // random word and threshold width
  localparam int unsigned WORD_W = 17;

  // configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHTNING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH    = 1'b1;
  localparam logic [WORD_W-1:0] LIGHTNING_RESET = 17'd2;
  localparam logic [WORD_W-1:0] GROWTH_RESET    = 17'd655;

  // cell codes
  typedef enum logic [1:0] {
    CELL_TREE  = 2'd0,
    CELL_FIRE  = 2'd1,
    CELL_EMPTY = 2'd2
  } cell_e;

  // operation codes
  typedef enum logic {
    OP_SEED   = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  // classified word, position-independent part
  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              nb_l;
    logic              nb_r;
    logic              nb_u;
    logic              nb_d;
  } ffa_ctl_t;

  localparam int unsigned CTL_W = $bits(ffa_ctl_t);

endpackage

`default_nettype wire

/* design/ffa_front.sv */
// ----------------------------------------------------------------------------
// ffa_front
// Scan position tracking and classification of incoming words.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_front #(
  parameter int unsigned GRID_WIDTH  = 128,
  parameter int unsigned GRID_HEIGHT = 64,
  parameter int unsigned XW = 7,
  parameter int unsigned YW = 6,
  parameter int unsigned AW = 13
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic                    operation_i,
  input  wire logic [ffa_pkg::WORD_W-1:0] random_word_i,
  output ffa_pkg::ffa_ctl_t            ctl_o,
  output logic [AW-1:0]                pos_o,
  output logic [XW-1:0]                x_o,
  output logic [YW-1:0]                y_o
);
  import ffa_pkg::*;

  logic [AW-1:0] pos_q, pos_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic          y_end, x_end, last;

  // edges of the grid
  always_comb begin
    y_end = (y_q == YW'(GRID_HEIGHT - 1));
    x_end = (x_q == XW'(GRID_WIDTH - 1));
    last  = y_end && x_end;
  end

  // classify the word
  always_comb begin
    ctl_o.op   = op_e'(operation_i);
    ctl_o.word = random_word_i;
    ctl_o.last = last;
    ctl_o.nb_l = (x_q != '0);
    ctl_o.nb_r = !x_end;
    ctl_o.nb_u = (y_q != '0);
    ctl_o.nb_d = !y_end;
    pos_o      = pos_q;
    x_o        = x_q;
    y_o        = y_q;
  end

  // next scan position, y runs fastest
  always_comb begin
    pos_d = pos_q;
    x_d   = x_q;
    y_d   = y_q;
    if (accept_i) begin
      if (last) begin
        pos_d = '0;
        x_d   = '0;
        y_d   = '0;
      end else if (y_end) begin
        pos_d = pos_q + AW'(1);
        x_d   = x_q + XW'(1);
        y_d   = '0;
      end else begin
        pos_d = pos_q + AW'(1);
        y_d   = y_q + YW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else begin
      pos_q <= pos_d;
      x_q   <= x_d;
      y_q   <= y_d;
    end
  end

endmodule

`default_nettype wire

/* design/ffa_queue.sv */
// ----------------------------------------------------------------------------
// ffa_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;

  always_comb begin
    full_o  = (count_q == 2'd2);
    valid_o = (count_q != 2'd0);
    data_o  = mem_q[rd_ptr_q];
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/ffa_back.sv */
// ----------------------------------------------------------------------------
// ffa_back
// Grid storage, cell rule evaluation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_back #(
  parameter int unsigned GRID_WIDTH  = 128,
  parameter int unsigned GRID_HEIGHT = 64,
  parameter int unsigned XW = 7,
  parameter int unsigned YW = 6,
  parameter int unsigned AW = 13
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ffa_pkg::WORD_W-1:0]  cfg_data_i,
  input  wire logic                        q_valid_i,
  input  ffa_pkg::ffa_ctl_t                q_ctl_i,
  input  wire logic [AW-1:0]               q_pos_i,
  input  wire logic [XW-1:0]               q_x_i,
  input  wire logic [YW-1:0]               q_y_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [XW-1:0]                    column_o,
  output logic [YW-1:0]                    row_o,
  output logic [1:0]                       new_state_o,
  output logic                             pixel_on_o,
  output logic                             last_of_frame_o
);
  import ffa_pkg::*;

  localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned NRD   = 5;

  // each cell word holds both generation banks
  logic [3:0] mem_a [CELLS];
  logic [3:0] mem_b [CELLS];
  logic [3:0] mem_c [CELLS];

  logic [WORD_W-1:0] lightning_q, growth_q;
  logic              sel_q;

  // cell-stage registers
  logic              b_valid_q;
  ffa_ctl_t          b_ctl_q;
  logic [AW-1:0]     b_pos_q;
  logic [XW-1:0]     b_x_q;
  logic [YW-1:0]     b_y_q;
  logic [3:0]        rd_q   [NRD];
  logic [NRD-1:0]    fwd_q;
  logic [3:0]        fwd_word_q;

  // result register
  logic              out_valid_q;
  logic [XW-1:0]     col_q;
  logic [YW-1:0]     row_q;
  logic [1:0]        state_q;
  logic              pix_q, last_q;

  logic [AW-1:0]     raddr [NRD];
  logic [3:0]        cw    [NRD];
  logic [1:0]        cur_bits [NRD];
  logic              b_adv, is_update, exposed;
  cell_e             cur, nxt;
  logic              pix;
  logic              wr_en;
  logic [3:0]        wr_word;
  logic [1:0]        seed_bits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lightning_q <= LIGHTNING_RESET;
      growth_q    <= GROWTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LIGHTNING: lightning_q <= cfg_data_i;
        CFG_GROWTH:    growth_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // neighbor read addresses, off-grid ones fall back on the cell itself
  always_comb begin
    raddr[0] = q_pos_i;
    raddr[1] = q_ctl_i.nb_u ? q_pos_i - AW'(1) : q_pos_i;
    raddr[2] = q_ctl_i.nb_d ? q_pos_i + AW'(1) : q_pos_i;
    raddr[3] = q_ctl_i.nb_l ? q_pos_i - AW'(GRID_HEIGHT) : q_pos_i;
    raddr[4] = q_ctl_i.nb_r ? q_pos_i + AW'(GRID_HEIGHT) : q_pos_i;
  end

  // stage handshake
  always_comb begin
    is_update = (b_ctl_q.op == OP_UPDATE);
    b_adv     = b_valid_q && (!is_update || !out_valid_q || !out_stall_i);
    q_pop_o   = q_valid_i && (!b_valid_q || b_adv);
    wr_en     = b_adv;
  end

  // cell words with bypass of the write in flight
  always_comb begin
    for (int i = 0; i < NRD; i++) begin
      cw[i]       = fwd_q[i] ? fwd_word_q : rd_q[i];
      cur_bits[i] = sel_q ? cw[i][3:2] : cw[i][1:0];
    end
  end

  // rule evaluation
  always_comb begin
    cur     = cell_e'(cur_bits[0]);
    exposed = (b_ctl_q.nb_u && cur_bits[1] == CELL_FIRE) ||
              (b_ctl_q.nb_d && cur_bits[2] == CELL_FIRE) ||
              (b_ctl_q.nb_l && cur_bits[3] == CELL_FIRE) ||
              (b_ctl_q.nb_r && cur_bits[4] == CELL_FIRE);
    nxt = CELL_EMPTY;
    pix = 1'b0;
    case (cur)
      CELL_FIRE: begin
        nxt = CELL_EMPTY;
        pix = 1'b0;
      end
      CELL_TREE: begin
        nxt = (exposed || b_ctl_q.word <= lightning_q) ? CELL_FIRE : CELL_TREE;
        pix = 1'b1;
      end
      default: begin
        if (b_ctl_q.word <= growth_q) begin
          nxt = CELL_TREE;
          pix = 1'b1;
        end else begin
          nxt = CELL_EMPTY;
          pix = 1'b0;
        end
      end
    endcase
  end

  // word written back: seeds set both banks, updates the next bank only
  always_comb begin
    seed_bits = b_ctl_q.word[0] ? CELL_EMPTY : CELL_TREE;
    if (!is_update) begin
      wr_word = {seed_bits, seed_bits};
    end else if (sel_q) begin
      wr_word = {cur_bits[0], nxt};
    end else begin
      wr_word = {nxt, cur_bits[0]};
    end
  end

  // grid memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a[b_pos_q] <= wr_word;
      mem_b[b_pos_q] <= wr_word;
      mem_c[b_pos_q] <= wr_word;
    end
    if (q_pop_o) begin
      rd_q[0] <= mem_a[raddr[0]];
      rd_q[1] <= mem_a[raddr[1]];
      rd_q[2] <= mem_b[raddr[2]];
      rd_q[3] <= mem_b[raddr[3]];
      rd_q[4] <= mem_c[raddr[4]];
    end
  end

  // cell-stage payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_ctl_q    <= q_ctl_i;
      b_pos_q    <= q_pos_i;
      b_x_q      <= q_x_i;
      b_y_q      <= q_y_i;
      fwd_word_q <= wr_word;
      for (int i = 0; i < NRD; i++) begin
        fwd_q[i] <= wr_en && (b_pos_q == raddr[i]);
      end
    end
  end

  // cell-stage valid and bank select, flipped by a frame commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      sel_q     <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv && is_update && b_ctl_q.last) begin
        sel_q <= ~sel_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv && is_update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && is_update) begin
      col_q   <= b_x_q;
      row_q   <= b_y_q;
      state_q <= nxt;
      pix_q   <= pix;
      last_q  <= b_ctl_q.last;
    end
  end

  always_comb begin
    out_valid_o     = out_valid_q;
    column_o        = col_q;
    row_o           = row_q;
    new_state_o     = state_q;
    pixel_on_o      = pix_q;
    last_of_frame_o = last_q;
  end

endmodule

`default_nettype wire

/* design/forest_fire_automaton_step_top.sv */
// Path: queue entry, cell-stage registers, result register. Throughput: one
// word per cycle while no stall holds it; the grid memories take one write and
// all five neighbor reads in each cycle, with the write in flight bypassed.
// Reset: scan position zero, thresholds 2 and 655, grid contents undefined
// until seeded; no clearing pass.
// ----------------------------------------------------------------------------
// forest_fire_automaton_step_top
// Forest fire cellular automaton stepping one cell per word in scan order.
// ----------------------------------------------------------------------------
`default_nettype none

module forest_fire_automaton_step_top #(
  parameter int unsigned GRID_WIDTH  = 128,
  parameter int unsigned GRID_HEIGHT = 64,
  parameter int unsigned XW = $clog2(GRID_WIDTH),
  parameter int unsigned YW = $clog2(GRID_HEIGHT)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ffa_pkg::WORD_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [ffa_pkg::WORD_W-1:0]    random_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [XW-1:0]                      column_o,
  output logic [YW-1:0]                      row_o,
  output logic [1:0]                         new_state_o,
  output logic                               pixel_on_o,
  output logic                               last_of_frame_o
);
  import ffa_pkg::*;

  localparam int unsigned AW  = $clog2(GRID_WIDTH * GRID_HEIGHT);
  localparam int unsigned QW  = CTL_W + AW + XW + YW;

  logic          accept, q_full, q_valid, q_pop;
  ffa_ctl_t      f_ctl, q_ctl;
  logic [AW-1:0] f_pos, q_pos;
  logic [XW-1:0] f_x, q_x;
  logic [YW-1:0] f_y, q_y;
  logic [QW-1:0] q_din, q_dout;

  always_comb begin
    in_stall_o = q_full;
    accept     = in_valid_i && !q_full;
    q_din      = {f_ctl, f_pos, f_x, f_y};
    {q_ctl, q_pos, q_x, q_y} = q_dout;
  end

  // front: scan position and classification
  ffa_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .random_word_i(random_word_i),
    .ctl_o        (f_ctl),
    .pos_o        (f_pos),
    .x_o          (f_x),
    .y_o          (f_y)
  );

  // queue between front and back
  ffa_queue #(
    .DATA_W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (q_din),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_dout)
  );

  // back: grid storage and cell rules
  ffa_back #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_valid_i      (q_valid),
    .q_ctl_i        (q_ctl),
    .q_pos_i        (q_pos),
    .q_x_i          (q_x),
    .q_y_i          (q_y),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_o       (column_o),
    .row_o          (row_o),
    .new_state_o    (new_state_o),
    .pixel_on_o     (pixel_on_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

`default_nettype wire
